// ===== src/hrf_pkg.sv =====
// Shared types, constants and character tables for the HTTP request framer.
// No dependencies; every other file in src refers to this package by scoped name.
package hrf_pkg;

  // Request buffer size in bytes and the count width that holds it
  localparam int BUF_BYTES = 16384;
  localparam int CNT_W     = $clog2(BUF_BYTES + 1);

  // Fixed widths of the result fields
  localparam int FIELD_W   = 15;
  localparam int LEN_W     = 15;
  localparam int LEN_MUL_W = LEN_W + 4;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Byte queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Matcher constants
  localparam logic [3:0] KEY_LEN   = 4'd15;
  localparam logic [3:0] PATH_LEN  = 4'd6;
  localparam logic [3:0] PATH_FAIL = 4'd15;
  localparam logic [7:0] CASE_FOLD = 8'd32;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_UP_G  = 8'h47;
  localparam logic [7:0] CH_LO_C  = 8'h63;

  typedef enum logic [1:0] {
    KIND_READY     = 2'd0,
    KIND_SCORE     = 2'd1,
    KIND_NOT_FOUND = 2'd2,
    KIND_OVERSIZE  = 2'd3
  } kind_t;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_connection;
  } in_t;

  // Result word
  typedef struct packed {
    kind_t              request_kind;
    logic [FIELD_W-1:0] total_length;
    logic [FIELD_W-1:0] body_offset;
    logic [FIELD_W-1:0] body_length;
  } out_t;

  // Classified byte, as queued between front and back
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] low;
    logic [3:0] digit;
    logic       is_digit;
    logic       is_space;
    logic       is_tab;
    logic       is_cr;
    logic       is_lf;
    logic       is_p;
    logic       is_g;
    logic       low_is_c;
    logic       new_connection;
  } class_t;

  // "content-length:" one character per index
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3A; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "/ready"
  function automatic logic [7:0] path_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h2F; // /
      3'd1:    c = 8'h72; // r
      3'd2:    c = 8'h65; // e
      3'd3:    c = 8'h61; // a
      3'd4:    c = 8'h64; // d
      3'd5:    c = 8'h79; // y
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== src/hrf_front.sv =====
// Front end: classifies each incoming byte (case fold, digit, blanks, CR/LF, method letters).
// Depends on hrf_pkg.
module hrf_front (
  input  hrf_pkg::in_t    item,
  output hrf_pkg::class_t cls
);

  logic [7:0] b;
  logic       upper;

  assign b     = item.data_byte;
  assign upper = (b >= hrf_pkg::CH_UP_A) && (b <= hrf_pkg::CH_UP_Z);

  always_comb begin
    cls.data_byte      = b;
    cls.low            = upper ? (b + hrf_pkg::CASE_FOLD) : b;
    cls.is_digit       = (b >= hrf_pkg::CH_ZERO) && (b <= hrf_pkg::CH_NINE);
    cls.digit          = 4'(b - hrf_pkg::CH_ZERO);
    cls.is_space       = (b == hrf_pkg::CH_SPACE);
    cls.is_tab         = (b == hrf_pkg::CH_TAB);
    cls.is_cr          = (b == hrf_pkg::CH_CR);
    cls.is_lf          = (b == hrf_pkg::CH_LF);
    cls.is_p           = (b == hrf_pkg::CH_UP_P);
    cls.is_g           = (b == hrf_pkg::CH_UP_G);
    cls.low_is_c       = (cls.low == hrf_pkg::CH_LO_C);
    cls.new_connection = item.new_connection;
  end

endmodule

// ===== src/hrf_fifo.sv =====
// Short queue of classified bytes between front and back.
// Depends on hrf_pkg.
module hrf_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  hrf_pkg::class_t wdata,
  output logic            full,
  input  logic            rd,
  output hrf_pkg::class_t rdata,
  output logic            empty
);

  hrf_pkg::class_t             q [hrf_pkg::QDEPTH];
  logic [hrf_pkg::QPTR_W-1:0]  wr_ptr;
  logic [hrf_pkg::QPTR_W-1:0]  rd_ptr;
  logic [hrf_pkg::QCNT_W-1:0]  count;

  assign full  = (count == hrf_pkg::QCNT_W'(hrf_pkg::QDEPTH));
  assign empty = (count == '0);
  assign rdata = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/hrf_back.sv =====
// Back end: request parser (terminator, method, path, content-length) and result buffer.
// Depends on hrf_pkg.
module hrf_back (
  input  logic            clk,
  input  logic            rst,
  input  hrf_pkg::class_t item,
  input  logic            item_valid,
  output logic            item_take,
  input  logic            pop,
  output logic            empty,
  output hrf_pkg::out_t   result
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DROP   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    MC_OTHER = 2'd0,
    MC_POST  = 2'd1,
    MC_GET   = 2'd2
  } method_t;

  typedef enum logic [1:0] {
    VP_KEY    = 2'd0,
    VP_BLANK  = 2'd1,
    VP_DIGITS = 2'd2,
    VP_DONE   = 2'd3
  } vphase_t;

  // parser state
  logic [hrf_pkg::CNT_W-1:0] byte_count, byte_count_next;
  phase_t                    phase, phase_next;
  logic [1:0]                terminator_match, terminator_match_next;
  method_t                   method_class, method_class_next;
  logic [1:0]                space_count, space_count_next;
  logic [3:0]                path_match, path_match_next;
  logic [3:0]                key_match, key_match_next;
  vphase_t                   value_phase, value_phase_next;
  logic [hrf_pkg::LEN_W-1:0] length_value, length_value_next;
  logic [hrf_pkg::CNT_W-1:0] header_length, header_length_next;
  logic [hrf_pkg::LEN_W-1:0] body_remaining, body_remaining_next;

  logic [hrf_pkg::CNT_W-1:0]     cnt1;
  logic [2:0]                    term_new;
  logic [hrf_pkg::LEN_MUL_W-1:0] mul_val;
  logic                          emit;
  logic                          clr_req;
  hrf_pkg::out_t                 res;

  // result buffer, two words
  hrf_pkg::out_t ob [2];
  logic          ob_wr;
  logic          ob_rd;
  logic [1:0]    ob_cnt;
  logic          ob_push;
  logic          ob_pop;

  assign item_take = item_valid && (ob_cnt != 2'd2);
  assign ob_push   = item_take && emit;
  assign ob_pop    = pop && (ob_cnt != 2'd0);
  assign empty     = (ob_cnt == 2'd0);
  assign result    = ob[ob_rd];

  // times ten plus digit, widened to catch saturation
  assign mul_val = hrf_pkg::LEN_MUL_W'({length_value, 3'b000})
                 + hrf_pkg::LEN_MUL_W'({length_value, 1'b0})
                 + hrf_pkg::LEN_MUL_W'(item.digit);

  always_comb begin
    byte_count_next       = byte_count;
    phase_next            = phase;
    terminator_match_next = terminator_match;
    method_class_next     = method_class;
    space_count_next      = space_count;
    path_match_next       = path_match;
    key_match_next        = key_match;
    value_phase_next      = value_phase;
    length_value_next     = length_value;
    header_length_next    = header_length;
    body_remaining_next   = body_remaining;
    cnt1                  = byte_count + 1'b1;
    term_new              = 3'd0;
    emit                  = 1'b0;
    clr_req               = 1'b0;
    res                   = '0;

    if (item.new_connection) begin
      byte_count_next       = '0;
      phase_next            = PH_HEADER;
      terminator_match_next = '0;
      method_class_next     = MC_OTHER;
      space_count_next      = '0;
      path_match_next       = '0;
      key_match_next        = '0;
      value_phase_next      = VP_KEY;
      length_value_next     = '0;
      header_length_next    = '0;
      body_remaining_next   = '0;
    end

    cnt1 = byte_count_next + 1'b1;

    unique case (phase_next)
      PH_HEADER: begin
        byte_count_next = cnt1;
        if (cnt1 == hrf_pkg::CNT_W'(1)) begin
          method_class_next = item.is_p ? MC_POST : (item.is_g ? MC_GET : MC_OTHER);
        end

        // path between first and second space
        if (space_count_next == 2'd0) begin
          if (item.is_space) space_count_next = 2'd1;
        end else if (space_count_next == 2'd1) begin
          if (item.is_space) begin
            space_count_next = 2'd2;
          end else if (path_match_next < hrf_pkg::PATH_LEN &&
                       item.data_byte == hrf_pkg::path_char(path_match_next[2:0])) begin
            path_match_next = path_match_next + 1'b1;
          end else begin
            path_match_next = hrf_pkg::PATH_FAIL;
          end
        end

        // key and value
        unique case (value_phase_next)
          VP_KEY: begin
            if (key_match_next < hrf_pkg::KEY_LEN &&
                item.low == hrf_pkg::key_char(key_match_next)) begin
              key_match_next = key_match_next + 1'b1;
              if (key_match_next == hrf_pkg::KEY_LEN) value_phase_next = VP_BLANK;
            end else begin
              key_match_next = {3'b000, item.low_is_c};
            end
          end
          VP_BLANK: begin
            if (item.is_digit) begin
              length_value_next = hrf_pkg::LEN_W'(item.digit);
              value_phase_next  = VP_DIGITS;
            end else if (!item.is_space && !item.is_tab) begin
              value_phase_next = VP_DONE;
            end
          end
          VP_DIGITS: begin
            if (item.is_digit) begin
              length_value_next = (mul_val > hrf_pkg::LEN_MUL_W'(hrf_pkg::LEN_MAX))
                                ? hrf_pkg::LEN_MAX : mul_val[hrf_pkg::LEN_W-1:0];
            end else begin
              value_phase_next = VP_DONE;
            end
          end
          default: ;
        endcase

        // CR LF CR LF
        if ((terminator_match_next == 2'd0 || terminator_match_next == 2'd2) && item.is_cr) begin
          term_new = {1'b0, terminator_match_next} + 1'b1;
        end else if ((terminator_match_next == 2'd1 || terminator_match_next == 2'd3) &&
                     item.is_lf) begin
          term_new = {1'b0, terminator_match_next} + 1'b1;
        end else begin
          term_new = {2'b00, item.is_cr};
        end
        terminator_match_next = term_new[1:0];

        if (term_new == 3'd4) begin
          header_length_next = cnt1;
          if (method_class_next == MC_POST) begin
            if (length_value_next == '0) begin
              emit                 = 1'b1;
              clr_req              = 1'b1;
              res.request_kind     = hrf_pkg::KIND_SCORE;
              res.total_length     = hrf_pkg::FIELD_W'(cnt1);
              res.body_offset      = hrf_pkg::FIELD_W'(cnt1);
              res.body_length      = '0;
            end else begin
              body_remaining_next = length_value_next;
              phase_next          = PH_BODY;
            end
          end else begin
            emit             = 1'b1;
            clr_req          = 1'b1;
            res.request_kind = (method_class_next == MC_GET && space_count_next == 2'd2 &&
                                path_match_next == hrf_pkg::PATH_LEN)
                             ? hrf_pkg::KIND_READY : hrf_pkg::KIND_NOT_FOUND;
            res.total_length = hrf_pkg::FIELD_W'(cnt1);
          end
        end
      end
      PH_BODY: begin
        byte_count_next = cnt1;
        if (body_remaining_next != '0) begin
          body_remaining_next = body_remaining_next - 1'b1;
        end
        if (body_remaining_next == '0) begin
          emit             = 1'b1;
          clr_req          = 1'b1;
          phase_next       = PH_HEADER;
          res.request_kind = hrf_pkg::KIND_SCORE;
          res.total_length = hrf_pkg::FIELD_W'(cnt1);
          res.body_offset  = hrf_pkg::FIELD_W'(header_length_next);
          res.body_length  = hrf_pkg::FIELD_W'(length_value_next);
        end
      end
      default: ; // dropping: no count, no result
    endcase

    // buffer limit reached without a complete request
    if ((phase_next == PH_HEADER || phase_next == PH_BODY) && !emit &&
        cnt1 >= hrf_pkg::CNT_W'(hrf_pkg::BUF_BYTES) &&
        (phase == PH_HEADER || phase == PH_BODY || item.new_connection)) begin
      emit             = 1'b1;
      clr_req          = 1'b1;
      phase_next       = PH_DROP;
      res.request_kind = hrf_pkg::KIND_OVERSIZE;
      res.total_length = hrf_pkg::FIELD_W'(hrf_pkg::BUF_BYTES);
    end

    if (clr_req) begin
      byte_count_next       = '0;
      terminator_match_next = '0;
      method_class_next     = MC_OTHER;
      space_count_next      = '0;
      path_match_next       = '0;
      key_match_next        = '0;
      value_phase_next      = VP_KEY;
      length_value_next     = '0;
      header_length_next    = '0;
      body_remaining_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      phase            <= PH_HEADER;
      terminator_match <= '0;
      method_class     <= MC_OTHER;
      space_count      <= '0;
      path_match       <= '0;
      key_match        <= '0;
      value_phase      <= VP_KEY;
      length_value     <= '0;
      header_length    <= '0;
      body_remaining   <= '0;
    end else if (item_take) begin
      byte_count       <= byte_count_next;
      phase            <= phase_next;
      terminator_match <= terminator_match_next;
      method_class     <= method_class_next;
      space_count      <= space_count_next;
      path_match       <= path_match_next;
      key_match        <= key_match_next;
      value_phase      <= value_phase_next;
      length_value     <= length_value_next;
      header_length    <= header_length_next;
      body_remaining   <= body_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob[ob_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr  <= 1'b0;
      ob_rd  <= 1'b0;
      ob_cnt <= 2'd0;
    end else begin
      if (ob_push) ob_wr <= ~ob_wr;
      if (ob_pop)  ob_rd <= ~ob_rd;
      unique case ({ob_push, ob_pop})
        2'b10:   ob_cnt <= ob_cnt + 1'b1;
        2'b01:   ob_cnt <= ob_cnt - 1'b1;
        default: ob_cnt <= ob_cnt;
      endcase
    end
  end

endmodule

// ===== src/http_request_framer.sv =====
// Throughput: one byte word per cycle; the back end steps the parser once per byte and
//   stalls only while its two-word result buffer is full.
// Path: a byte's result reaches the result ports through the byte queue, then the result
//   buffer, both registered; a full result buffer holds it back while it stays full.
// Reset: rst is synchronous, active high; empties both queues, parser back to header phase.
// Depends on hrf_pkg, hrf_front, hrf_fifo, hrf_back.
module http_request_framer (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  hrf_pkg::in_t  item,
  output logic          empty,
  input  logic          pop,
  output hrf_pkg::out_t result
);

  // Front end: classify the byte as it arrives, so the back end sees flags, not raw compares
  hrf_pkg::class_t cls;
  hrf_pkg::class_t q_word;
  logic            q_empty;
  logic            q_take;

  hrf_front u_front (
    .item (item),
    .cls  (cls)
  );

  // Four-word queue decouples the input from a stalled result side
  hrf_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (push && !full),
    .wdata (cls),
    .full  (full),
    .rd    (q_take),
    .rdata (q_word),
    .empty (q_empty)
  );

  // Back end: parser state and result buffer; it takes a word whenever the buffer has room,
  // so a byte flows through every cycle while the consumer pops at the same rate
  hrf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (q_word),
    .item_valid (!q_empty),
    .item_take  (q_take),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule

// ===== dv/tb_http_request_framer.sv =====
`timescale 1ns / 1ps
// Self-checking bench for http_request_framer: drives byte words through the push/full
// side and checks every descriptor word popped against a framing predictor held here.
// Depends on hrf_pkg and the framer RTL.

typedef enum logic [1:0] {PH_HEADER, PH_BODY, PH_DROP} frame_phase_t;
typedef enum logic [1:0] {VAL_KEY, VAL_BLANKS, VAL_DIGITS, VAL_DONE} value_state_t;
typedef enum logic [1:0] {METH_OTHER, METH_POST, METH_GET} req_method_t;

localparam logic [8*15-1:0] KEY_TEXT  = "content-length:";
localparam logic [8*6-1:0]  PATH_TEXT = "/ready";
localparam logic [3:0]      PATH_MISS = 4'd15;
localparam int              LEN_CAP   = 32767;
localparam logic [7:0]      CR        = 8'h0D;
localparam logic [7:0]      LF        = 8'h0A;
localparam logic [7:0]      TAB       = 8'h09;
localparam logic [7:0]      SPACE     = 8'h20;

class framer_scoreboard;
  // predictor state, one copy of the parser
  logic [14:0]    byte_count, length_value, header_length, body_left;
  logic [2:0]     crlf_match;
  logic [1:0]     spaces;
  logic [3:0]     path_match, key_match;
  frame_phase_t   phase;
  value_state_t   value_state;
  req_method_t    method;

  hrf_pkg::out_t  descriptors_due[$];
  int             errors, checked, predicted;
  int             kind_count[4];

  function new();
    clear_request();
    phase = PH_HEADER;
  endfunction

  function void clear_request();
    byte_count    = '0;
    crlf_match    = '0;
    method        = METH_OTHER;
    spaces        = '0;
    path_match    = '0;
    key_match     = '0;
    value_state   = VAL_KEY;
    length_value  = '0;
    header_length = '0;
    body_left     = '0;
  endfunction

  function int pending();
    return descriptors_due.size();
  endfunction

  function void expect_descriptor(hrf_pkg::kind_t kind, logic [14:0] total,
                                  logic [14:0] offset, logic [14:0] blen);
    hrf_pkg::out_t d;
    d.request_kind = kind;
    d.total_length = total;
    d.body_offset  = offset;
    d.body_length  = blen;
    descriptors_due.push_back(d);
    predicted++;
  endfunction

  function void scan_header_byte(logic [7:0] b);
    logic [7:0] low;
    int v;
    low = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    if (byte_count == 15'd1)
      method = (b == "P") ? METH_POST : (b == "G") ? METH_GET : METH_OTHER;

    // path sits between the first and second space
    if (spaces == 2'd0) begin
      if (b == SPACE) spaces = 2'd1;
    end else if (spaces == 2'd1) begin
      if (b == SPACE) spaces = 2'd2;
      else if (path_match < 4'd6 && b == PATH_TEXT[8*(5-int'(path_match)) +: 8])
        path_match++;
      else path_match = PATH_MISS;
    end

    case (value_state)
      VAL_KEY: begin
        if (key_match < 4'd15 && low == KEY_TEXT[8*(14-int'(key_match)) +: 8]) begin
          key_match++;
          if (key_match == 4'd15) value_state = VAL_BLANKS;
        end else begin
          key_match = (low == "c") ? 4'd1 : 4'd0;
        end
      end
      VAL_BLANKS: begin
        if (b >= "0" && b <= "9") begin
          length_value = 15'(b - "0");
          value_state  = VAL_DIGITS;
        end else if (b != SPACE && b != TAB) begin
          value_state = VAL_DONE;
        end
      end
      VAL_DIGITS: begin
        if (b >= "0" && b <= "9") begin
          v = int'(length_value) * 10 + int'(b - "0");
          length_value = (v > LEN_CAP) ? 15'(LEN_CAP) : 15'(v);
        end else begin
          value_state = VAL_DONE;
        end
      end
      default: ;
    endcase

    if ((crlf_match == 3'd0 || crlf_match == 3'd2) && b == CR) crlf_match++;
    else if ((crlf_match == 3'd1 || crlf_match == 3'd3) && b == LF) crlf_match++;
    else crlf_match = (b == CR) ? 3'd1 : 3'd0;
  endfunction

  // one accepted byte word; queues the descriptor it completes, if any
  function void note_byte(hrf_pkg::in_t w);
    if (w.new_connection) begin
      clear_request();
      phase = PH_HEADER;
    end
    if (phase == PH_DROP) return;
    byte_count++;
    if (phase == PH_HEADER) begin
      scan_header_byte(w.data_byte);
      if (crlf_match == 3'd4) begin
        header_length = byte_count;
        crlf_match    = '0;
        if (method == METH_POST) begin
          if (length_value == '0) begin
            expect_descriptor(hrf_pkg::KIND_SCORE, byte_count, header_length, '0);
            clear_request();
            return;
          end
          body_left = length_value;
          phase     = PH_BODY;
        end else begin
          expect_descriptor((method == METH_GET && spaces == 2'd2 && path_match == 4'd6) ?
                            hrf_pkg::KIND_READY : hrf_pkg::KIND_NOT_FOUND,
                            byte_count, '0, '0);
          clear_request();
          return;
        end
      end
    end else begin
      if (body_left != '0) body_left--;
      if (body_left == '0) begin
        expect_descriptor(hrf_pkg::KIND_SCORE, byte_count, header_length, length_value);
        clear_request();
        phase = PH_HEADER;
        return;
      end
    end
    if (int'(byte_count) >= hrf_pkg::BUF_BYTES) begin
      expect_descriptor(hrf_pkg::KIND_OVERSIZE, 15'(hrf_pkg::BUF_BYTES), '0, '0);
      clear_request();
      phase = PH_DROP;
    end
  endfunction

  task report(string field, logic [31:0] got_v, logic [31:0] want_v);
    $display("[%0t] descriptor %0d: %s is %0d, expected %0d", $time, checked, field,
             got_v, want_v);
    errors++;
  endtask

  task check_result(hrf_pkg::out_t got);
    hrf_pkg::out_t want;
    checked++;
    if (descriptors_due.size() == 0) begin
      report("unlooked-for word, total_length", got.total_length, 0);
      return;
    end
    want = descriptors_due.pop_front();
    kind_count[want.request_kind]++;
    if (got.request_kind !== want.request_kind)
      report("request_kind", got.request_kind, want.request_kind);
    if (got.total_length !== want.total_length)
      report("total_length", got.total_length, want.total_length);
    if (got.body_offset !== want.body_offset)
      report("body_offset", got.body_offset, want.body_offset);
    if (got.body_length !== want.body_length)
      report("body_length", got.body_length, want.body_length);
  endtask
endclass

module tb_http_request_framer;

  // Slowest honest run is well under a thousand byte words, each after a random sender gap,
  // plus a few long hold-offs; LIMIT leaves more than ten times that in hand.
  localparam int LIMIT       = 50_000;
  localparam int ITEMS       = 600;  // random traffic goes on starting requests until this many byte words are sent
  localparam int HOLD_CYCLES = 80;   // long consumer hold-off, enough to back up the queues
  localparam int TAIL_CYCLES = 16;   // result passes the byte queue, then the result buffer; generous tail

  logic          clk, rst;
  logic          push, full, empty, pop;
  hrf_pkg::in_t  item;
  hrf_pkg::out_t result;

  http_request_framer dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  framer_scoreboard sb;
  logic [7:0] req_bytes[$];   // request under construction
  bit  idle_on;               // when clear, both sides run flat out
  int  hold_reqs;             // bumped by the sender to ask the receiver for a long hold-off
  int  cycles = 0;
  int  full_stalls = 0;
  int  words_sent;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d descriptors outstanding", cycles,
               sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Both handshakes sampled at the edge, before the edge's own updates land: an accepted
  // byte feeds the predictor, an accepted descriptor is checked against the oldest due.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_byte(item);
      if (push && full) full_stalls++;
      if (pop && !empty) sb.check_result(result);
    end
  end

  // ---------------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------------

  // Offer one byte word and hold it until the framer takes it.
  task automatic send_word(input logic [7:0] b, input logic fresh);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push                <= 1'b1;
    item.data_byte      <= b;
    item.new_connection <= fresh;
    do @(posedge clk); while (full);
    words_sent++;
  endtask

  // Send the built request; fresh marks its first byte as the start of a connection.
  task automatic send_request(input logic fresh);
    foreach (req_bytes[i]) send_word(req_bytes[i], fresh && i == 0);
    req_bytes.delete();
  endtask

  // Stop offering and wait until every descriptor due has been popped.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver holds off while a run of bare terminators streams in back to back, each on a
  // fresh connection: the two-word result buffer fills, then the byte queue, and full rises.
  task automatic hold_burst();
    bit saved;
    saved   = idle_on;
    idle_on = 1'b0;
    hold_reqs++;
    repeat (12) begin
      add_eol();
      add_eol();
      send_request(1'b1);
    end
    idle_on = saved;
  endtask

  task automatic send_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      // lean on CR and LF so partial terminators turn up often
      case ($urandom_range(0, 3))
        0:       b = CR;
        1:       b = LF;
        default: b = 8'($urandom);
      endcase
      send_word(b, $urandom_range(0, 15) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------------

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endfunction

  function automatic void add_eol();
    req_bytes.push_back(CR);
    req_bytes.push_back(LF);
  endfunction

  // key in random letter case; the framer folds case
  function automatic void add_key();
    string key;
    key = "content-length:";
    for (int i = 0; i < key.len(); i++)
      if (key[i] >= "a" && key[i] <= "z" && $urandom_range(0, 1))
        req_bytes.push_back(key[i] - 8'd32);
      else req_bytes.push_back(key[i]);
  endfunction

  function automatic void add_headers();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       add_text("Host: localhost");
        1:       add_text("Accept: */*");
        2:       add_text("Content-Type: application/json");  // shares a prefix with the key
        default: add_text("X-Trace:\tabc");
      endcase
      add_eol();
    end
  endfunction

  // Adds a length header in one of several shapes; returns the body length it declares.
  function automatic int add_length_header();
    int value, shape;
    shape = $urandom_range(0, 9);
    value = $urandom_range(0, 40);
    if (shape == 0) return 0;          // no key at all
    add_key();
    repeat ($urandom_range(0, 2)) req_bytes.push_back($urandom_range(0, 1) ? SPACE : TAB);
    if (shape == 1) begin              // key with no digits
      add_text("none");
      add_eol();
      return 0;
    end
    if (shape == 2) add_text("000");   // leading zeros
    add_text($sformatf("%0d", value));
    add_eol();
    if (shape == 3) begin              // a later key is ignored
      add_key();
      add_text(" 7");
      add_eol();
    end
    return value;
  endfunction

  function automatic void add_post(string len_line, int body);
    add_text("POST /payments HTTP/1.1");
    add_eol();
    if (len_line.len() != 0) begin
      add_text(len_line);
      add_eol();
    end
    add_eol();
    repeat (body) req_bytes.push_back(8'($urandom));
  endfunction

  // One well-formed request with random content.
  function automatic void build_request();
    int pick, blen;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      add_text("GET /ready HTTP/1.1");
      add_eol();
      add_headers();
      add_eol();
    end else if (pick < 35) begin
      case ($urandom_range(0, 4))
        0:       add_text("GET /read HTTP/1.1");
        1:       add_text("GET /readyz HTTP/1.1");
        2:       add_text("GET /Ready HTTP/1.1");
        3:       add_text("DELETE /ready HTTP/1.1");
        default: add_text("GET /payments-summary?from=1 HTTP/1.1");
      endcase
      add_eol();
      add_headers();
      add_eol();
    end else begin
      // anything opening with P is framed as a scoring post, PUT included
      add_text(pick < 90 ? "POST /payments HTTP/1.1" : "PUT /ready HTTP/1.1");
      add_eol();
      add_headers();
      blen = add_length_header();
      add_headers();
      add_eol();
      repeat (blen) req_bytes.push_back(8'($urandom));
    end
  endfunction

  // ---------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------

  task automatic run_directed();
    // ready probe on a fresh connection, with a header line to skip
    add_text("GET /ready HTTP/1.1");
    add_eol();
    add_text("Host: lb");
    add_eol();
    add_eol();
    send_request(1'b1);
    // scoring post, mixed-case key, body holding both extreme byte values and CR LF
    add_post("CONTENT-Length:  4", 0);
    req_bytes.push_back(8'h00);
    req_bytes.push_back(8'hFF);
    req_bytes.push_back(CR);
    req_bytes.push_back(LF);
    send_request(1'b0);
    // zero length: descriptor at the header end, no body
    add_post("content-length: 0", 0);
    send_request(1'b0);
    // key absent
    add_post("", 0);
    send_request(1'b0);
    // tab and space ahead of the digits
    add_post("content-length:\t 3", 3);
    send_request(1'b0);
    // key with no digits
    add_post("content-length: abc", 0);
    send_request(1'b0);
    // only the first key counts
    add_post("content-length: 2\r\nContent-Length: 9", 2);
    send_request(1'b0);
    // near misses on the probe path and method
    add_text("GET /readyz HTTP/1.1");
    add_eol();
    add_eol();
    add_text("GET /Ready HTTP/1.1");
    add_eol();
    add_eol();
    add_text("HEAD /ready HTTP/1.1");
    add_eol();
    add_eol();
    send_request(1'b0);
    // bare terminator
    add_eol();
    add_eol();
    send_request(1'b0);
    // a fresh connection cuts a post short in its body
    add_post("content-length: 30", 5);
    send_request(1'b0);
    add_text("GET /ready HTTP/1.1");
    add_eol();
    add_eol();
    send_request(1'b1);
    drain();
  endtask

  task automatic run_random();
    int pick;
    bit resync;
    resync = 1'b1;            // random traffic opens on a fresh connection
    hold_burst();
    drain();
    while (words_sent < ITEMS) begin
      if ($urandom_range(0, 9) == 0) idle_on = !idle_on;
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        build_request();
        send_request(resync || $urandom_range(0, 7) == 0);
        resync = 1'b0;
      end else if (pick < 93) begin
        send_noise($urandom_range(1, 24));
        resync = 1'b1;
      end else begin
        // truncated request; whatever state it leaves is cleared by the next fresh start
        build_request();
        repeat ($urandom_range(1, req_bytes.size() - 1)) void'(req_bytes.pop_back());
        send_request(resync);
        resync = 1'b1;
      end
      if ($urandom_range(0, 49) == 0) drain();
      if ($urandom_range(0, 99) == 0) hold_burst();
    end
  endtask

  // Receiver: random stall per descriptor, or one long hold-off when asked.
  initial begin
    int stall, holds_done;
    pop        = 1'b0;
    holds_done = 0;
    wait (rst === 1'b0);
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (holds_done != hold_reqs) begin
        holds_done = hold_reqs;
        stall      = HOLD_CYCLES;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  initial begin
    sb         = new();
    rst        = 1'b1;
    push       = 1'b0;
    item       = '0;
    idle_on    = 1'b1;
    hold_reqs  = 0;
    words_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_random();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("framer run: %0d byte words, %0d descriptors (ready %0d, post %0d, not found %0d)",
             words_sent, sb.checked, sb.kind_count[hrf_pkg::KIND_READY],
             sb.kind_count[hrf_pkg::KIND_SCORE], sb.kind_count[hrf_pkg::KIND_NOT_FOUND]);
    $display("input held off by full on %0d cycles; %0d mismatches in %0d cycles",
             full_stalls, sb.errors, cycles);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/hrf_pkg.sv
src/hrf_front.sv
src/hrf_fifo.sv
src/hrf_back.sv
src/http_request_framer.sv
dv/tb_http_request_framer.sv
